[sv/rgbhsv_pkg.sv]
// Shared constants and types for the RGB to HSV conversion pipeline.
`default_nettype none

package rgbhsv_pkg;

   // Fraction bits of saturation and of one hue sector.
   localparam int FRAC_BITS = 12;

   // Fixed field widths of the pixel and result channels.
   localparam int CHAN_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 13;

   // Both divisions have a numerator no larger than the divisor, so the
   // quotient never exceeds 2^FRAC_BITS and the partial remainder fits in
   // one bit more than a channel.
   localparam int QUO_W           = FRAC_BITS + 1;
   localparam int REM_W           = CHAN_W + 1;
   localparam int DIV_STEPS       = FRAC_BITS + 1;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // Two front stages, the divider stages and the output register.
   localparam int LATENCY = DIV_STAGES + 3;

   // Signed working width of the hue sum; holds six sectors plus a sign.
   localparam int HSUM_W = (FRAC_BITS + 4 > HUE_W + 1) ? FRAC_BITS + 4 : HUE_W + 1;
   // Working width for fitting the quotient to the saturation field.
   localparam int SATX_W = (QUO_W > SAT_W) ? QUO_W : SAT_W;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Pixel information that rides alongside the two divisions.
   typedef struct packed {
      logic [CHAN_W-1:0] value;
      logic              undef;
      logic              neg;
      sector_type        sector;
      logic              last;
   } side_type;

   // One lane of the restoring divider.
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [CHAN_W-1:0] den;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   // Everything one pipeline stage carries for one transaction.
   typedef struct packed {
      side_type side;
      lane_type sat;
      lane_type hue;
   } div_word_type;

endpackage

`default_nettype wire

[sv/rgbhsv_front.sv]
// Front stages: channel maximum and minimum, sector choice, delta and hue difference.
`default_nettype none

module rgbhsv_front import rgbhsv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [CHAN_W-1:0] red,
   input  wire logic [CHAN_W-1:0] green,
   input  wire logic [CHAN_W-1:0] blue,
   input  wire logic              last_in,
   output logic                   out_valid,
   output div_word_type           out_word
);

   logic              s1_valid_ff;
   logic [CHAN_W-1:0] s1_max_ff, s1_max_in;
   logic [CHAN_W-1:0] s1_min_ff, s1_min_in;
   sector_type        s1_sector_ff, s1_sector_in;
   logic [CHAN_W:0]   s1_diff_ff, s1_diff_in;
   logic              s1_last_ff;

   logic              s2_valid_ff;
   div_word_type      s2_word_ff, s2_word_in;

   logic [CHAN_W-1:0] delta;
   logic [CHAN_W:0]   abs_diff;
   logic              diff_neg;

   // Ties go to red first, then green, as the sector order requires.
   always_comb begin
      if (red >= green && red >= blue) begin
         s1_sector_in = SECTOR_RED;
         s1_max_in    = red;
         s1_diff_in   = {1'b0, green} - {1'b0, blue};
      end else if (green >= blue) begin
         s1_sector_in = SECTOR_GREEN;
         s1_max_in    = green;
         s1_diff_in   = {1'b0, blue} - {1'b0, red};
      end else begin
         s1_sector_in = SECTOR_BLUE;
         s1_max_in    = blue;
         s1_diff_in   = {1'b0, red} - {1'b0, green};
      end
      if (red <= green && red <= blue) begin
         s1_min_in = red;
      end else if (green <= blue) begin
         s1_min_in = green;
      end else begin
         s1_min_in = blue;
      end
   end

   always_comb begin
      delta    = s1_max_ff - s1_min_ff;
      diff_neg = s1_diff_ff[CHAN_W];
      abs_diff = diff_neg ? (~s1_diff_ff + 1'b1) : s1_diff_ff;

      s2_word_in.side.value  = s1_max_ff;
      s2_word_in.side.undef  = (delta == '0);
      s2_word_in.side.neg    = diff_neg;
      s2_word_in.side.sector = s1_sector_ff;
      s2_word_in.side.last   = s1_last_ff;

      s2_word_in.sat.rem = {1'b0, delta};
      s2_word_in.sat.den = s1_max_ff;
      s2_word_in.sat.quo = '0;

      s2_word_in.hue.rem = {1'b0, abs_diff[CHAN_W-1:0]};
      s2_word_in.hue.den = delta;
      s2_word_in.hue.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_max_ff    <= s1_max_in;
      s1_min_ff    <= s1_min_in;
      s1_sector_ff <= s1_sector_in;
      s1_diff_ff   <= s1_diff_in;
      s1_last_ff   <= last_in;
      s2_word_ff   <= s2_word_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

`default_nettype wire

[sv/rgbhsv_div.sv]
// Pipelined two-lane restoring divider for saturation and hue fraction.
`default_nettype none

module rgbhsv_div import rgbhsv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire div_word_type  in_word,
   output logic               out_valid,
   output div_word_type       out_word
);

   // One restoring step. The first step compares without a shift, since the
   // numerator never exceeds the divisor.
   function automatic lane_type div_step(input lane_type lane, input logic shift);
      lane_type         res;
      logic [REM_W-1:0] part;
      res  = lane;
      part = shift ? {lane.rem[REM_W-2:0], 1'b0} : lane.rem;
      if (part >= {1'b0, lane.den}) begin
         res.rem = part - {1'b0, lane.den};
         res.quo = {lane.quo[QUO_W-2:0], 1'b1};
      end else begin
         res.rem = part;
         res.quo = {lane.quo[QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

   div_word_type stage_ff [DIV_STAGES];
   div_word_type stage_in [DIV_STAGES];
   div_word_type src      [DIV_STAGES];
   logic         valid_ff [DIV_STAGES];

   always_comb begin
      int idx;
      src[0] = in_word;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src[s] = stage_ff[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_in[s] = src[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            idx = s * STEPS_PER_STAGE + j;
            if (idx < DIV_STEPS) begin
               stage_in[s].sat = div_step(stage_in[s].sat, idx != 0);
               stage_in[s].hue = div_step(stage_in[s].hue, idx != 0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_word  = stage_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

[sv/rgbhsv_back.sv]
// Output stage: hue assembly with sector offset and wrap, saturation fix-up, result register.
`default_nettype none

module rgbhsv_back import rgbhsv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire div_word_type      in_word,
   output logic                   out_valid,
   output logic [HUE_W-1:0]       hue,
   output logic [SAT_W-1:0]       saturation,
   output logic [CHAN_W-1:0]      value,
   output logic                   hue_undefined,
   output logic                   last_out
);

   logic              valid_ff;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [SAT_W-1:0]  sat_ff, sat_in;
   logic [CHAN_W-1:0] value_ff;
   logic              undef_ff;
   logic              last_ff;

   logic              round_up;
   logic [QUO_W:0]    frac_mag;
   logic [HSUM_W-1:0] base;
   logic [HSUM_W-1:0] hue_sum;
   logic [SATX_W-1:0] sat_wide;

   // A negative difference is floored: the magnitude rounds up when the
   // division left a remainder.
   always_comb begin
      round_up = in_word.side.neg && (in_word.hue.rem != '0);
      frac_mag = {1'b0, in_word.hue.quo} + (QUO_W + 1)'(round_up);
      case (in_word.side.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = HSUM_W'(2) << FRAC_BITS;
         SECTOR_BLUE:  base = HSUM_W'(4) << FRAC_BITS;
         default:      base = '0;
      endcase
      if (in_word.side.neg) begin
         hue_sum = base - HSUM_W'(frac_mag);
      end else begin
         hue_sum = base + HSUM_W'(frac_mag);
      end
      if (hue_sum[HSUM_W-1]) begin
         hue_sum = hue_sum + (HSUM_W'(6) << FRAC_BITS);
      end
      hue_in = in_word.side.undef ? '0 : hue_sum[HUE_W-1:0];

      // A black pixel divides by zero; its saturation is forced to zero.
      sat_wide = SATX_W'(in_word.sat.quo);
      sat_in   = (in_word.side.value == '0) ? '0 : sat_wide[SAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      value_ff <= in_word.side.value;
      undef_ff <= in_word.side.undef;
      last_ff  <= in_word.side.last;
   end

   assign out_valid     = valid_ff;
   assign hue           = hue_ff;
   assign saturation    = sat_ff;
   assign value         = value_ff;
   assign hue_undefined = undef_ff;
   assign last_out      = last_ff;

endmodule

`default_nettype wire

[sv/rgb_to_hsv_converter.sv]
// Top level of the pipelined RGB to HSV converter.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start, busy          req_red, req_green, req_blue, req_last_in
//   response  out        rsp_valid (strobe)   rsp_hue, rsp_saturation, rsp_value,
//                                             rsp_hue_undefined, rsp_last_out
//
// A transaction is accepted on every clock edge where start is high; busy is
// never raised, so one pixel can enter on every cycle.
// Each result passes through two front stages, one stage per two quotient bits of
// the two parallel restoring dividers, and the output register.
// Synchronous reset clears only the valid bits of the pipeline; data registers
// keep whatever they hold and are ignored until a valid bit reaches them.
// The receiver takes every strobed result, so the pipeline never stalls.
`default_nettype none

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [CHAN_W-1:0] req_red,
   input  wire logic [CHAN_W-1:0] req_green,
   input  wire logic [CHAN_W-1:0] req_blue,
   input  wire logic              req_last_in,
   output logic                   rsp_valid,
   output logic [HUE_W-1:0]       rsp_hue,
   output logic [SAT_W-1:0]       rsp_saturation,
   output logic [CHAN_W-1:0]      rsp_value,
   output logic                   rsp_hue_undefined,
   output logic                   rsp_last_out
);

   logic         accept;
   logic         front_valid;
   div_word_type front_word;
   logic         div_valid;
   div_word_type div_word;

   // The pipeline advances every cycle, so the request side is never held off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Maximum, minimum, sector and signed channel difference.
   rgbhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .last_in   (req_last_in),
      .out_valid (front_valid),
      .out_word  (front_word)
   );

   // Saturation (delta over max) and hue fraction (|diff| over delta) side by side.
   rgbhsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_word  (div_word)
   );

   // Sector offset, floor correction, wrap of negative hue, result register.
   rgbhsv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid),
      .in_word       (div_word),
      .out_valid     (rsp_valid),
      .hue           (rsp_hue),
      .saturation    (rsp_saturation),
      .value         (rsp_value),
      .hue_undefined (rsp_hue_undefined),
      .last_out      (rsp_last_out)
   );

endmodule

`default_nettype wire

[sv/rgbhsv_checker.sv]
// Port-level assertions for the RGB to HSV converter and their bind to the top level.
`default_nettype none

module rgbhsv_checker import rgbhsv_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic [HUE_W-1:0]  rsp_hue,
   input wire logic [SAT_W-1:0]  rsp_saturation,
   input wire logic [CHAN_W-1:0] rsp_value,
   input wire logic              rsp_hue_undefined
);

   // Every accepted transaction later yields a valid result.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted pixel produced no result at the pipeline latency");

   // A gray pixel reports zero hue.
   a_gray_hue : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hue_undefined) |-> (rsp_hue == '0))
      else $error("undefined hue is not reported as zero");

   // A colored pixel has a hue below one full turn.
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hue_undefined) |-> (rsp_hue < (6 << FRAC_BITS)))
      else $error("hue outside one turn");

   // Saturation is at most one and is zero exactly when the pixel is gray; a zero value implies gray.
   a_saturation : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_saturation <= (1 << FRAC_BITS)) &&
                     ((rsp_saturation == '0) == rsp_hue_undefined) &&
                     ((rsp_value != '0) || rsp_hue_undefined)))
      else $error("saturation inconsistent with gray flag or value");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (.*);

`default_nettype wire
